FILE: src/psw_pkg.sv
// Shared widths, microcode types and the control program of the priority scheduler.
package psw_pkg;

  localparam int unsigned BurstW              = 16;
  localparam int unsigned PrioW               = 8;
  localparam int unsigned IndexW              = 4;
  localparam int unsigned TimeW               = 20;
  localparam int unsigned MaxProcessesDefault = 16;
  localparam int unsigned StepW               = 4;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StLoad   = 4'd0;
  localparam step_t StIStart = 4'd1;
  localparam step_t StILatch = 4'd2;
  localparam step_t StJStep  = 4'd3;
  localparam step_t StSwRd   = 4'd4;
  localparam step_t StSwW1   = 4'd5;
  localparam step_t StSwW2   = 4'd6;
  localparam step_t StTRd    = 4'd7;
  localparam step_t StTAcc   = 4'd8;
  localparam step_t StDivW   = 4'd9;
  localparam step_t StDivWW  = 4'd10;
  localparam step_t StDivT   = 4'd11;
  localparam step_t StDivTW  = 4'd12;
  localparam step_t StERd    = 4'd13;
  localparam step_t StEOut   = 4'd14;
  localparam step_t StDone   = 4'd15;

  typedef enum logic [1:0] {A_NONE, A_I, A_K, A_K1}               a_src_e;
  typedef enum logic [1:0] {B_NONE, B_J, B_J1, B_SEL}             b_src_e;
  typedef enum logic [1:0] {W_NONE, W_IN, W_I_FROM_B, W_SEL_FROM_A} wr_e;
  typedef enum logic [2:0] {X_NONE, X_NEWI, X_SELP, X_SCAN, X_NEXTI} idx_op_e;
  typedef enum logic [1:0] {C_NONE, C_CLR, C_SUM, C_EMIT}         acc_op_e;
  typedef enum logic [2:0] {D_NONE, D_START_W, D_START_T, D_TAKE_W, D_TAKE_T} div_op_e;
  typedef enum logic [1:0] {S_NONE, S_IN, S_DIV, S_OUT}           stall_e;
  typedef enum logic [2:0] {F_CLOSE, F_JEND, F_J1END, F_IEND, F_KEND} flag_e;
  typedef enum logic [1:0] {J_NEXT, J_GOTO, J_IF, J_IFNOT}        cond_e;

  typedef struct packed {
    a_src_e  a_src;
    b_src_e  b_src;
    wr_e     wr;
    idx_op_e idx_op;
    acc_op_e acc_op;
    div_op_e div_op;
    stall_e  stall;
    flag_e   flag;
    cond_e   cond;
    step_t   target;
  } ctrl_t;

  function automatic ctrl_t prog_word(step_t step);
    ctrl_t w;
    w = '{a_src: A_NONE, b_src: B_NONE, wr: W_NONE, idx_op: X_NONE, acc_op: C_NONE,
          div_op: D_NONE, stall: S_NONE, flag: F_CLOSE, cond: J_NEXT, target: StLoad};
    case (step)
      StLoad: begin
        w.wr = W_IN; w.stall = S_IN; w.flag = F_CLOSE; w.cond = J_IFNOT; w.target = StLoad;
      end
      StIStart: begin
        w.a_src = A_I; w.idx_op = X_NEWI;
      end
      StILatch: begin
        w.b_src = B_J; w.idx_op = X_SELP; w.flag = F_JEND; w.cond = J_IF; w.target = StSwRd;
      end
      StJStep: begin
        w.b_src = B_J1; w.idx_op = X_SCAN; w.flag = F_J1END; w.cond = J_IFNOT;
        w.target = StJStep;
      end
      StSwRd: begin
        w.a_src = A_I; w.b_src = B_SEL;
      end
      StSwW1: begin
        w.wr = W_I_FROM_B;
      end
      StSwW2: begin
        w.wr = W_SEL_FROM_A; w.idx_op = X_NEXTI; w.flag = F_IEND; w.cond = J_IFNOT;
        w.target = StIStart;
      end
      StTRd: begin
        w.a_src = A_K; w.acc_op = C_CLR;
      end
      StTAcc: begin
        w.a_src = A_K1; w.acc_op = C_SUM; w.flag = F_KEND; w.cond = J_IFNOT;
        w.target = StTAcc;
      end
      StDivW: begin
        w.div_op = D_START_W;
      end
      StDivWW: begin
        w.div_op = D_TAKE_W; w.stall = S_DIV;
      end
      StDivT: begin
        w.div_op = D_START_T;
      end
      StDivTW: begin
        w.div_op = D_TAKE_T; w.stall = S_DIV; w.acc_op = C_CLR;
      end
      StERd: begin
        w.a_src = A_K;
      end
      StEOut: begin
        w.acc_op = C_EMIT; w.stall = S_OUT; w.flag = F_KEND; w.cond = J_IFNOT;
        w.target = StERd;
      end
      StDone: begin
        w.cond = J_GOTO; w.target = StLoad;
      end
      default: begin
        w.cond = J_GOTO; w.target = StLoad;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/psw_ifs.sv
// Valid/ready channels for process words in and schedule words out.
interface psw_in_if import psw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BurstW-1:0] burst_time;
  logic [PrioW-1:0]  priority_level;
  logic              last_item;

  modport source (output valid, burst_time, priority_level, last_item, input ready);
  modport sink   (input valid, burst_time, priority_level, last_item, output ready);
endinterface

interface psw_out_if import psw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] process_index;
  logic [BurstW-1:0] burst_out;
  logic [PrioW-1:0]  priority_out;
  logic [TimeW-1:0]  wait_time;
  logic [TimeW-1:0]  turnaround_time;
  logic [TimeW-1:0]  average_wait;
  logic [TimeW-1:0]  average_turnaround;
  logic              final_result;

  modport source (output valid, process_index, burst_out, priority_out, wait_time,
                  turnaround_time, average_wait, average_turnaround, final_result,
                  input ready);
  modport sink   (input valid, process_index, burst_out, priority_out, wait_time,
                  turnaround_time, average_wait, average_turnaround, final_result,
                  output ready);
endinterface

FILE: src/psw_div.sv
// Serial restoring divider, one quotient bit per cycle.
module psw_div #(
  parameter int unsigned DIVIDEND_W = 28,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      rem_d = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: src/priority_schedule_wait_times.sv
// Top level: batch loader, microcoded selection sort, wait/turnaround totals and emitter.
//
//  channel | dir | word                                                    | accepted when
//  in_i    | in  | burst_time, priority_level, last_item                   | valid && ready
//  out_o   | out | process_index, burst_out, priority_out, wait_time,       | valid && ready
//          |     | turnaround_time, average_wait, average_turnaround,      |
//          |     | final_result                                            |
//
// Loading writes each accepted word into the store. A batch of n closes on last_item or when
// the store fills; then the sequencer runs the sort (one compare per cycle on the two-port
// store), the totals, both averages in the shared serial divider and the emission; input is
// taken only while loading.
// Reset clears the sequencer, counters and output valid; the store needs no clearing.
// A stalled output holds the emit step; the registered result word frees the store reads.
module priority_schedule_wait_times import psw_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MaxProcessesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psw_in_if.sink    in_i,
  psw_out_if.source out_o
);

  localparam int unsigned IDX_W    = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned ELAP_W   = BurstW + CNT_W;
  localparam int unsigned TOT_W    = BurstW + 2 * CNT_W;
  localparam int unsigned PRIO_LSB = BurstW;
  localparam int unsigned IDX_LSB  = BurstW + PrioW;
  localparam int unsigned ENTRY_W  = IDX_W + PrioW + BurstW;

  // sequencer
  step_t step_q, step_d;
  ctrl_t cw;
  logic  stall, go, flag;

  // counters and pointers
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] sel_q, sel_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] j_inc, k_inc, i_inc2;
  logic [PrioW-1:0] selp_q, selp_d;

  // store
  logic [ENTRY_W-1:0] mem_q [MAX_PROCESSES];
  logic [ENTRY_W-1:0] a_q, b_q;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   wr_addr, a_addr, b_addr;
  logic               wr_en, a_en, b_en;
  logic [BurstW-1:0]  a_burst;
  logic [PrioW-1:0]   a_prio, b_prio;
  logic [IDX_W-1:0]   a_idx;

  // accumulation and division
  logic [ELAP_W-1:0] elapsed_q, elapsed_d, el_new;
  logic [TOT_W-1:0]  tot_wait_q, tot_wait_d;
  logic [TOT_W-1:0]  tot_turn_q, tot_turn_d;
  logic [TimeW-1:0]  avg_wait_q, avg_wait_d;
  logic [TimeW-1:0]  avg_turn_q, avg_turn_d;
  logic              div_start, div_done;
  logic [TOT_W-1:0]  div_dividend, div_quotient;

  // output word
  logic              out_valid_q, out_valid_d, out_load;
  logic [IndexW-1:0] o_idx_q;
  logic [BurstW-1:0] o_burst_q;
  logic [PrioW-1:0]  o_prio_q;
  logic [TimeW-1:0]  o_wait_q, o_turn_q, o_avgw_q, o_avgt_q;
  logic              o_final_q;

  logic in_fire, closing;

  assign cw      = prog_word(step_q);
  assign in_fire = in_i.valid && in_i.ready;
  assign closing = in_i.last_item || (cnt_q == CNT_W'(MAX_PROCESSES - 1));

  assign j_inc  = j_q + CNT_W'(1);
  assign k_inc  = k_q + CNT_W'(1);
  assign i_inc2 = i_q + CNT_W'(2);

  assign a_burst = a_q[BurstW-1:0];
  assign a_prio  = a_q[IDX_LSB-1:PRIO_LSB];
  assign a_idx   = a_q[ENTRY_W-1:IDX_LSB];
  assign b_prio  = b_q[IDX_LSB-1:PRIO_LSB];
  assign el_new  = elapsed_q + ELAP_W'(a_burst);

  always_comb begin
    case (cw.stall)
      S_IN:    stall = !in_fire;
      S_DIV:   stall = !div_done;
      S_OUT:   stall = out_valid_q && !out_o.ready;
      default: stall = 1'b0;
    endcase
    go = !stall;
  end

  always_comb begin
    case (cw.flag)
      F_CLOSE: flag = closing;
      F_JEND:  flag = j_q >= n_q;
      F_J1END: flag = j_inc >= n_q;
      F_IEND:  flag = i_inc2 >= n_q;
      F_KEND:  flag = k_inc >= n_q;
      default: flag = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      case (cw.cond)
        J_GOTO:  step_d = cw.target;
        J_IF:    step_d = flag ? cw.target : step_q + StepW'(1);
        J_IFNOT: step_d = flag ? step_q + StepW'(1) : cw.target;
        default: step_d = step_q + StepW'(1);
      endcase
    end
  end

  // store ports
  always_comb begin
    case (cw.a_src)
      A_K:     a_addr = k_q[IDX_W-1:0];
      A_K1:    a_addr = k_inc[IDX_W-1:0];
      default: a_addr = i_q[IDX_W-1:0];
    endcase
    case (cw.b_src)
      B_J1:    b_addr = j_inc[IDX_W-1:0];
      B_SEL:   b_addr = sel_q[IDX_W-1:0];
      default: b_addr = j_q[IDX_W-1:0];
    endcase
    a_en = go && (cw.a_src != A_NONE);
    b_en = go && (cw.b_src != B_NONE);
    case (cw.wr)
      W_IN: begin
        wr_addr = cnt_q[IDX_W-1:0];
        wr_data = {cnt_q[IDX_W-1:0], in_i.priority_level, in_i.burst_time};
      end
      W_I_FROM_B: begin
        wr_addr = i_q[IDX_W-1:0];
        wr_data = b_q;
      end
      default: begin
        wr_addr = sel_q[IDX_W-1:0];
        wr_data = a_q;
      end
    endcase
    wr_en = go && (cw.wr != W_NONE);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (a_en) begin
      a_q <= mem_q[a_addr];
    end
    if (b_en) begin
      b_q <= mem_q[b_addr];
    end
  end

  // datapath
  always_comb begin
    cnt_d      = cnt_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    sel_d      = sel_q;
    k_d        = k_q;
    selp_d     = selp_q;
    elapsed_d  = elapsed_q;
    tot_wait_d = tot_wait_q;
    tot_turn_d = tot_turn_q;
    avg_wait_d = avg_wait_q;
    avg_turn_d = avg_turn_q;
    out_load   = 1'b0;
    div_start  = 1'b0;

    if (go) begin
      if (cw.wr == W_IN) begin
        if (closing) begin
          n_d   = cnt_q + CNT_W'(1);
          cnt_d = '0;
          i_d   = '0;
          k_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      case (cw.idx_op)
        X_NEWI: begin
          sel_d = i_q;
          j_d   = i_q + CNT_W'(1);
        end
        X_SELP: selp_d = a_prio;
        X_SCAN: begin
          if (b_prio < selp_q) begin
            sel_d  = j_q;
            selp_d = b_prio;
          end
          j_d = j_inc;
        end
        X_NEXTI: i_d = i_q + CNT_W'(1);
        default: ;
      endcase

      case (cw.acc_op)
        C_CLR: begin
          elapsed_d  = '0;
          tot_wait_d = '0;
          tot_turn_d = '0;
          k_d        = '0;
        end
        C_SUM: begin
          tot_wait_d = tot_wait_q + TOT_W'(elapsed_q);
          tot_turn_d = tot_turn_q + TOT_W'(el_new);
          elapsed_d  = el_new;
          k_d        = k_inc;
        end
        C_EMIT: begin
          out_load  = 1'b1;
          elapsed_d = el_new;
          k_d       = k_inc;
        end
        default: ;
      endcase

      case (cw.div_op)
        D_START_W, D_START_T: div_start = 1'b1;
        D_TAKE_W:             avg_wait_d = TimeW'(div_quotient);
        D_TAKE_T:             avg_turn_d = TimeW'(div_quotient);
        default: ;
      endcase
    end
  end

  assign div_dividend = (cw.div_op == D_START_T) ? tot_turn_q : tot_wait_q;

  psw_div #(
    .DIVIDEND_W(TOT_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (n_q),
    .quotient_o(div_quotient),
    .done_o    (div_done)
  );

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StLoad;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      sel_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      sel_q       <= sel_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    selp_q     <= selp_d;
    elapsed_q  <= elapsed_d;
    tot_wait_q <= tot_wait_d;
    tot_turn_q <= tot_turn_d;
    avg_wait_q <= avg_wait_d;
    avg_turn_q <= avg_turn_d;
    if (out_load) begin
      o_idx_q   <= IndexW'(a_idx);
      o_burst_q <= a_burst;
      o_prio_q  <= a_prio;
      o_wait_q  <= TimeW'(elapsed_q);
      o_turn_q  <= TimeW'(el_new);
      o_avgw_q  <= avg_wait_q;
      o_avgt_q  <= avg_turn_q;
      o_final_q <= k_inc >= n_q;
    end
  end

  assign in_i.ready               = (step_q == StLoad);
  assign out_o.valid              = out_valid_q;
  assign out_o.process_index      = o_idx_q;
  assign out_o.burst_out          = o_burst_q;
  assign out_o.priority_out       = o_prio_q;
  assign out_o.wait_time          = o_wait_q;
  assign out_o.turnaround_time    = o_turn_q;
  assign out_o.average_wait       = o_avgw_q;
  assign out_o.average_turnaround = o_avgt_q;
  assign out_o.final_result       = o_final_q;

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> cnt_q < CNT_W'(MAX_PROCESSES))
    else $error("fill count past store depth");

  a_sel_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StSwRd) |-> (sel_q >= i_q && sel_q < n_q))
    else $error("selected entry outside unsorted part");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_done) |-> (step_q == StDivWW || step_q == StDivTW))
    else $error("divider finished outside a wait step");

endmodule
